FILE: src/assert_macros.svh
// Assertion macros for the RTL of the six-bit character packer, used by its top-level core.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBP_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SBP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/sbp_pkg.sv
// Package for the six-bit character packer: character map, hex digit table
// and the result bundle passed from the packer to the output buffer. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sbp_pkg;

	localparam int unsigned CodeW  = 6;
	localparam int unsigned DigitW = 7;
	localparam int unsigned MaxDig = 4;
	localparam int unsigned DCntW  = 3;

	typedef struct packed {
		logic [DCntW-1:0]               cnt;
		logic                           last;
		logic [MaxDig-1:0][DigitW-1:0]  digits;
	} bundle_t;

	// Returns {hit, code}; hit is low for a character that carries no code.
	function automatic logic [CodeW:0] map_char(input logic [7:0] c);
		logic [CodeW:0] r;
		r = '0;
		if (c >= 8'd97 && c <= 8'd122) begin
			r = {1'b1, 6'(c - 8'd97)};
		end else if (c >= 8'd65 && c <= 8'd90) begin
			r = {1'b1, 6'(c - 8'd39)};
		end else if (c >= 8'd48 && c <= 8'd57) begin
			r = {1'b1, 6'(c + 8'd4)};
		end else if (c == 8'd32) begin
			r = {1'b1, 6'd62};
		end
		return r;
	endfunction

	function automatic logic [DigitW-1:0] hex_char(input logic [3:0] nib);
		logic [DigitW-1:0] r;
		if (nib < 4'd10) begin
			r = 7'd48 + {3'd0, nib};
		end else begin
			r = 7'd55 + {3'd0, nib};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: src/sbp_pack.sv
// Bit accumulator of the packer: maps one registered character, packs its
// code and forms up to two bytes as hex digits. Depends on sbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbp_pack import sbp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] char_s1,
	input  wire logic       end_s1,
	input  wire logic       adv,
	output bundle_t         bundle
);

	logic [5:0]  acc_q;
	logic [2:0]  cnt_q;
	logic [5:0]  acc_n;
	logic [2:0]  cnt_n;
	logic [CodeW:0] mapped;
	logic [11:0] comb;
	logic [11:0] shifted;
	logic [11:0] mask;
	logic [2:0]  rem_cnt;
	logic [2:0]  pad_sh;
	logic [13:0] padded;
	logic [7:0]  byte1;
	logic [7:0]  byte2;
	logic [7:0]  b0;
	logic        has1;
	logic        has2;

	always_comb begin
		mapped  = map_char(char_s1);
		comb    = {acc_q, mapped[CodeW-1:0]};
		rem_cnt = cnt_q - 3'd2;
		shifted = comb >> rem_cnt;
		mask    = (12'd1 << rem_cnt) - 12'd1;
		byte1   = shifted[7:0];
		has1    = 1'b0;
		acc_n   = acc_q;
		cnt_n   = cnt_q;
		if (mapped[CodeW]) begin
			if (cnt_q == 3'd0) begin
				acc_n = mapped[CodeW-1:0];
				cnt_n = 3'd6;
			end else begin
				has1  = 1'b1;
				acc_n = comb[5:0] & mask[5:0];
				cnt_n = rem_cnt;
			end
		end
		pad_sh = 3'(4'd8 - {1'b0, cnt_n});
		padded = {8'd0, acc_n} << pad_sh;
		byte2  = padded[7:0];
		has2   = end_s1 && (cnt_n != 3'd0);
		b0     = has1 ? byte1 : byte2;
		bundle.digits[0] = hex_char(b0[7:4]);
		bundle.digits[1] = hex_char(b0[3:0]);
		bundle.digits[2] = hex_char(byte2[7:4]);
		bundle.digits[3] = hex_char(byte2[3:0]);
		bundle.cnt  = {1'b0, has1, 1'b0} + {1'b0, has2, 1'b0};
		bundle.last = end_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
		end else if (adv) begin
			if (end_s1) begin
				acc_q <= '0;
				cnt_q <= '0;
			end else begin
				acc_q <= acc_n;
				cnt_q <= cnt_n;
			end
		end
	end

endmodule

`default_nettype wire

FILE: src/sbp_out.sv
// Output buffer of the packer: holds the hex digits of one item and sends
// them one transfer per cycle while out_stall is low. Depends on sbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbp_out import sbp_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bundle_t           bundle,
	input  wire logic              load,
	output logic                   buf_free,
	output logic [DigitW-1:0]      hex_digit,
	output logic                   out_last,
	output logic                   out_valid,
	input  wire logic              out_stall
);

	logic [MaxDig-1:0][DigitW-1:0] dig_q;
	logic [DCntW-1:0]              rem_q;
	logic                          last_q;
	logic                          take;

	assign out_valid = (rem_q != '0);
	assign take      = out_valid && !out_stall;
	assign buf_free  = (rem_q == '0) || (rem_q == 3'd1 && !out_stall);
	assign hex_digit = dig_q[0];
	assign out_last  = last_q && (rem_q == 3'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (load) begin
			rem_q <= bundle.cnt;
		end else if (take) begin
			rem_q <= rem_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dig_q  <= bundle.digits;
			last_q <= bundle.last;
		end else if (take) begin
			dig_q <= {{DigitW{1'b0}}, dig_q[MaxDig-1:1]};
		end
	end

endmodule

`default_nettype wire

FILE: src/six_bit_char_packer_hex_core.sv
// Six-bit character packer with hex output: input register, packer and output buffer.
// Depends on sbp_pkg, sbp_pack, sbp_out and assert_macros.svh.
//
// Usage:
// The input channel (in_valid, in_stall, char_in, msg_end) takes one ASCII character per
// transfer; msg_end marks the final character of a message. Letters, digits and space
// become 6-bit codes packed most significant bit first; other characters are dropped.
// The output channel (out_valid, out_stall, hex_digit, out_last) sends each completed
// byte as two uppercase ASCII hex digits, high nibble first. At the end of a message
// the leftover bits are zero padded to a byte and out_last marks the final digit.
// An input transfer passes the input register and the output buffer register before its
// first hex digit appears. The input register takes a new character every cycle while
// the output buffer can load; the output port sends one digit per cycle while out_stall
// is low, and an item yields 0, 2 or 4 digits.
// While the receiver stalls, the output buffer holds its digits and one more item waits
// in the input register; after that in_stall rises.
// Reset clears the bit accumulator and both valid flags; no output is shown after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module six_bit_char_packer_hex_core import sbp_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [7:0]        char_in,
	input  wire logic              msg_end,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [DigitW-1:0]      hex_digit,
	output logic                   out_last
);

	logic [7:0] char_s1;
	logic       end_s1;
	logic       vld_s1;
	logic       adv;
	logic       buf_free;
	logic       load_buf;
	logic       out_take;
	logic       hex_ok;
	bundle_t    bundle;

	assign adv      = vld_s1 && ((bundle.cnt == '0) || buf_free);
	assign in_stall = vld_s1 && !adv;
	assign load_buf = adv && (bundle.cnt != '0);
	assign out_take = out_valid && !out_stall;
	assign hex_ok   = ((hex_digit >= 7'd48) && (hex_digit <= 7'd57)) ||
		((hex_digit >= 7'd65) && (hex_digit <= 7'd70));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= char_in;
			end_s1  <= msg_end;
		end
	end

	sbp_pack u_pack (
		.clk     (clk),
		.arst_n  (arst_n),
		.char_s1 (char_s1),
		.end_s1  (end_s1),
		.adv     (adv),
		.bundle  (bundle)
	);

	sbp_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.bundle    (bundle),
		.load      (load_buf),
		.buf_free  (buf_free),
		.hex_digit (hex_digit),
		.out_last  (out_last),
		.out_valid (out_valid),
		.out_stall (out_stall)
	);

	`SBP_ASSERT_SAME(a_load_free, load_buf, buf_free, "load into busy buffer")
	`SBP_ASSERT_SAME(a_cnt_even, adv, !bundle.cnt[0] && (bundle.cnt <= 3'd4), "odd digit count")
	`SBP_ASSERT_SAME(a_hex_range, out_valid, hex_ok, "bad hex digit")
	`SBP_ASSERT_NEXT(a_last_ends, out_take && out_last, !out_last, "last mark misplaced")
	`SBP_ASSERT_NEXT(a_stall_hold, out_valid && out_stall, $stable(hex_digit), "held digit changed")

endmodule

`default_nettype wire

FILE: dv/tb_six_bit_char_packer_hex_core.sv
// Testbench for six_bit_char_packer_hex_core: drives characters over the input channel,
// predicts the hex digits and checks every output transfer in order.
// Depends on sbp_pkg and the RTL of the packer; it needs no other file.
`timescale 1ns / 1ps

module tb_six_bit_char_packer_hex_core import sbp_pkg::*;;

	localparam int StallLimit = 2000;
	localparam int HoldCycles = 300;
	localparam int ItemsPerPhase = 130;

	typedef struct packed {
		logic [DigitW-1:0] digit;
		logic              last;
	} hex_exp_t;

	typedef struct packed {
		logic [7:0]  ch;
		logic        fin;
		logic        known;
		logic [2:0]  nd;
		logic [31:0] txt;
	} char_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [7:0]        char_in = 8'd0;
	logic              msg_end = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b1;
	logic [DigitW-1:0] hex_digit;
	logic              out_last;

	hex_exp_t    hex_q[$];
	hex_exp_t    oldest_digit;
	logic [5:0]  pend_bits = 6'd0;
	logic [2:0]  pend_cnt = 3'd0;
	int unsigned src_idle_pct = 10;
	int unsigned sink_idle_pct = 88;
	int          err_cnt = 0;
	int          digits_seen = 0;
	int          hold_left = 0;
	int          idle_cycles = 0;

	char_row_t dir_rows [26] = '{
		'{8'd97,  1'b1, 1'b1, 3'd2, "00"},
		'{8'd122, 1'b1, 1'b1, 3'd2, "64"},
		'{8'd65,  1'b1, 1'b1, 3'd2, "68"},
		'{8'd90,  1'b1, 1'b1, 3'd2, "CC"},
		'{8'd48,  1'b1, 1'b1, 3'd2, "D0"},
		'{8'd57,  1'b1, 1'b1, 3'd2, "F4"},
		'{8'd32,  1'b1, 1'b1, 3'd2, "F8"},
		'{8'd255, 1'b1, 1'b1, 3'd0, 32'd0},
		'{8'd0,   1'b0, 1'b1, 3'd0, 32'd0},
		'{8'd96,  1'b0, 1'b1, 3'd0, 32'd0},
		'{8'd123, 1'b0, 1'b1, 3'd0, 32'd0},
		'{8'd64,  1'b0, 1'b1, 3'd0, 32'd0},
		'{8'd91,  1'b0, 1'b1, 3'd0, 32'd0},
		'{8'd47,  1'b0, 1'b1, 3'd0, 32'd0},
		'{8'd58,  1'b0, 1'b1, 3'd0, 32'd0},
		'{8'd33,  1'b0, 1'b1, 3'd0, 32'd0},
		'{8'd31,  1'b1, 1'b1, 3'd0, 32'd0},
		'{8'd97,  1'b0, 1'b0, 3'd0, 32'd0},
		'{8'd98,  1'b0, 1'b0, 3'd0, 32'd0},
		'{8'd99,  1'b1, 1'b0, 3'd0, 32'd0},
		'{8'd72,  1'b0, 1'b0, 3'd0, 32'd0},
		'{8'd33,  1'b1, 1'b0, 3'd0, 32'd0},
		'{8'd81,  1'b0, 1'b0, 3'd0, 32'd0},
		'{8'd122, 1'b0, 1'b0, 3'd0, 32'd0},
		'{8'd55,  1'b0, 1'b0, 3'd0, 32'd0},
		'{8'd32,  1'b1, 1'b0, 3'd0, 32'd0}
	};

	six_bit_char_packer_hex_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.char_in   (char_in),
		.msg_end   (msg_end),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.hex_digit (hex_digit),
		.out_last  (out_last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic flag_error(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		err_cnt++;
	endtask

	task automatic put_hex_byte(input logic [7:0] b);
		logic [3:0] nib;
		for (int k = 1; k >= 0; k--) begin
			nib = b[4*k +: 4];
			hex_q.push_back('{(nib < 4'd10) ? 7'd48 + 7'(nib) : 7'd55 + 7'(nib), 1'b0});
		end
	endtask

	task automatic pack_char(input logic [7:0] c, input logic fin);
		logic [13:0] acc;
		logic [5:0]  code;
		logic        hit;
		int unsigned cnt;
		int unsigned n_out;
		acc = {8'd0, pend_bits};
		cnt = pend_cnt;
		n_out = 0;
		hit = 1'b1;
		code = 6'd0;
		if (c >= "a" && c <= "z") begin
			code = 6'(c - "a");
		end else if (c >= "A" && c <= "Z") begin
			code = 6'(c - "A" + 8'd26);
		end else if (c >= "0" && c <= "9") begin
			code = 6'(c - "0" + 8'd52);
		end else if (c == " ") begin
			code = 6'd62;
		end else begin
			hit = 1'b0;
		end
		if (hit) begin
			acc = (acc << 6) | {8'd0, code};
			cnt += 6;
			if (cnt >= 8) begin
				put_hex_byte(8'(acc >> (cnt - 8)));
				n_out += 2;
				cnt -= 8;
				acc &= (14'd1 << cnt) - 14'd1;
			end
		end
		if (fin) begin
			if (cnt > 0) begin
				put_hex_byte(8'(acc << (8 - cnt)));
				n_out += 2;
			end
			if (n_out > 0) begin
				hex_q[hex_q.size() - 1].last = 1'b1;
			end
			acc = 14'd0;
			cnt = 0;
		end
		pend_bits = acc[5:0];
		pend_cnt = 3'(cnt);
	endtask

	task automatic send_char(input char_row_t r);
		int unsigned depth;
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		char_in <= r.ch;
		msg_end <= r.fin;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (r.known) begin
			depth = hex_q.size();
			pack_char(r.ch, r.fin);
			while (hex_q.size() > depth) void'(hex_q.pop_back());
			for (int i = 0; i < r.nd; i++) begin
				hex_q.push_back('{r.txt[8*(r.nd-1-i) +: 7], i == r.nd - 1});
			end
		end else begin
			pack_char(r.ch, r.fin);
		end
	endtask

	function automatic logic [7:0] pick_char(input bit noisy);
		if (noisy) return 8'($urandom_range(255));
		case ($urandom_range(9))
			0, 1, 2: return 8'("a" + $urandom_range(25));
			3, 4:    return 8'("A" + $urandom_range(25));
			5, 6:    return 8'("0" + $urandom_range(9));
			7:       return " ";
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (hex_q.size() == 0) begin
				flag_error($sformatf("unexpected digit 0x%0h last %0b", hex_digit, out_last));
			end else begin
				oldest_digit = hex_q.pop_front();
				if (hex_digit !== oldest_digit.digit) begin
					flag_error($sformatf("hex_digit 0x%0h, expected 0x%0h",
						hex_digit, oldest_digit.digit));
				end
				if (out_last !== oldest_digit.last) begin
					flag_error($sformatf("out_last %0b, expected %0b",
						out_last, oldest_digit.last));
				end
			end
			digits_seen++;
			if (digits_seen == 40 || digits_seen == 400) hold_left = HoldCycles;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < sink_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= StallLimit) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		char_row_t   r;
		int unsigned sent;
		int unsigned len;
		bit          noisy;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i]) send_char(dir_rows[i]);
		for (int ph = 0; ph < 3; ph++) begin
			src_idle_pct = (ph == 0) ? 10 : (ph == 1) ? 88 : 0;
			sink_idle_pct = (ph == 0) ? 88 : (ph == 1) ? 10 : 0;
			sent = 0;
			while (sent < ItemsPerPhase) begin
				noisy = ($urandom_range(7) == 0);
				len = $urandom_range(1, 12);
				for (int j = 0; j < len; j++) begin
					r = '0;
					r.ch = pick_char(noisy);
					r.fin = noisy ? ($urandom_range(3) == 0) : (j == len - 1);
					send_char(r);
				end
				sent += len;
			end
		end
		in_valid <= 1'b0;
		while (hex_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (err_cnt == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
